[sv/asa_pkg.sv]
// Shared types, codes and defaults for the aligned stack allocator.
package asa_pkg;

  localparam int unsigned REGION_BYTES_DEF = 4096;
  localparam int unsigned MAX_ALIGN_DEF    = 256;

  localparam int unsigned OFFS_W  = 13;
  localparam int unsigned ALIGN_W = 9;
  localparam int unsigned TAG_W   = 8;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [OFFS_W-1:0] REGION_SIZE_RST = 13'h1000;

  // Request kinds.
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_ALIGNED = 2'd1;
  localparam logic [1:0] OP_LOOKUP  = 2'd2;
  localparam logic [1:0] OP_FREE    = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_BAD_MARKER = 2'd2;
  localparam logic [1:0] ST_NULL       = 2'd3;

  typedef logic [OFFS_W-1:0] offs_t;

endpackage

[sv/aligned_stack_allocator_top.sv]
// Top level of the aligned stack allocator: top register, shift tag memory, output register.
// A request beat accepted into stage 1 moves on to the output register once that register
//   is empty or its beat is being taken, and out_tvalid rises from there.
// Throughput: one request per cycle while results are not stalled; the shift tag memory has
//   one read and one write port, and a read of the entry written in the same cycle is forwarded.
// Reset (rst_n low at a clock edge) clears the top to zero, sets region_size to 4096 and
//   empties the pipeline; the tag memory is not cleared and holds garbage until written.
module aligned_stack_allocator_top
  import asa_pkg::*;
#(
  parameter int unsigned REGION_BYTES = REGION_BYTES_DEF,
  parameter int unsigned MAX_ALIGN    = MAX_ALIGN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_wr_en,
  input  logic [OFFS_W-1:0]     cfg_wr_data,   // region_size

  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [12:0] size_bytes, [21:13] alignment, [34:22] offset_in, [39:35] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] operation, [2] offset_is_null
  input  logic [IN_USER_W-1:0]  in_tuser,

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [12:0] result_offset, [25:13] top_after, [31:26] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [OUT_USER_W-1:0] out_tuser
);

  // Address width of the tag memory; offsets are widened to 17 bits before the
  // address bits are picked so that any region size in range works.
  localparam int unsigned AW   = (REGION_BYTES > 1) ? $clog2(REGION_BYTES) : 1;
  localparam logic [16:0] RB17 = 17'(REGION_BYTES);
  localparam logic [ALIGN_W-1:0] MAX_ALIGN9 = ALIGN_W'(MAX_ALIGN);

  // Unpacked input fields.
  logic [1:0]         in_op;
  offs_t              in_size;
  logic [ALIGN_W-1:0] in_align;
  offs_t              in_offs;
  logic               in_null;

  assign in_size  = in_tdata[12:0];
  assign in_align = in_tdata[21:13];
  assign in_offs  = in_tdata[34:22];
  assign in_op    = in_tuser[1:0];
  assign in_null  = in_tuser[2];

  // Configuration and architectural top.
  offs_t region_size_r;
  offs_t top_r;

  // Stage 1: the request being resolved, with the tag read landing this cycle.
  logic               s1_valid_r;
  logic [1:0]         s1_op_r;
  offs_t              s1_size_r;
  logic [ALIGN_W-1:0] s1_align_r;
  offs_t              s1_offs_r;
  logic               s1_lk_null_r;

  // Output register.
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  offs_t              out_result_r;
  offs_t              out_top_r;

  // Handshake.
  logic s1_adv;
  logic in_fire;
  logic s1_fire;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = rst_n && (!s1_valid_r || s1_adv);
  assign in_fire   = in_tvalid && in_tready;
  assign s1_fire   = s1_valid_r && s1_adv;

  // A lookup whose pointer is null, zero, or past the region has no tag below it.
  logic        in_lk_null;
  logic [16:0] in_offs17;
  offs_t       in_offs_m1;
  logic [16:0] rd_addr17;
  logic [AW-1:0] rd_addr;
  logic        rd_en;

  assign in_offs17  = {4'b0, in_offs};
  assign in_lk_null = in_null || (in_offs == '0) || (in_offs17 > RB17);
  assign in_offs_m1 = in_offs - 13'd1;
  assign rd_addr17  = {4'b0, in_offs_m1};
  assign rd_addr    = rd_addr17[AW-1:0];
  assign rd_en      = in_fire && (in_op == OP_LOOKUP) && !in_lk_null;

  // Shift tag memory: one write port driven by stage 1, one registered read port.
  logic [TAG_W-1:0] tag_mem [REGION_BYTES];
  logic [TAG_W-1:0] rd_data_r;
  logic             fwd_r;
  logic [TAG_W-1:0] fwd_data_r;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [TAG_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= tag_mem[rd_addr];
    end
  end

  // The request in stage 1 may write the very entry the incoming lookup reads;
  // capture the write data so stage 1 sees the new tag next cycle.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_r      <= wr_en && rd_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  // Stage 1 resolution.
  offs_t       lim;
  logic [13:0] plain_end;
  logic [14:0] algn_end;
  logic        algn_ok;
  logic [ALIGN_W-1:0] align_m1;
  offs_t       slot;
  logic [13:0] aligned14;
  logic [13:0] shift14;
  logic [16:0] slot17;
  logic [TAG_W-1:0] tag_eff;
  logic [8:0]  shift9;

  logic [1:0]  status_nxt;
  offs_t       result_nxt;
  offs_t       top_nxt;

  always_comb begin
    // Usable limit is the smaller of region_size and the region's real size.
    if ({4'b0, region_size_r} > RB17) begin
      lim = RB17[12:0];
    end else begin
      lim = region_size_r;
    end

    plain_end = {1'b0, top_r} + {1'b0, s1_size_r};
    algn_end  = {2'b0, top_r} + {2'b0, s1_size_r} + {6'b0, s1_align_r};
    algn_ok   = $onehot(s1_align_r) && (s1_align_r <= MAX_ALIGN9);
    align_m1  = s1_align_r - 9'd1;

    // Round the top up to the next multiple of the alignment; an aligned top moves one full step.
    slot      = top_r | {4'b0, align_m1};
    aligned14 = {1'b0, slot} + 14'd1;
    shift14   = aligned14 - {1'b0, top_r};
    slot17    = {4'b0, slot};

    tag_eff = fwd_r ? fwd_data_r : rd_data_r;
    shift9  = (tag_eff == '0) ? 9'd256 : {1'b0, tag_eff};

    status_nxt = ST_OK;
    result_nxt = '0;
    top_nxt    = top_r;
    wr_en      = 1'b0;
    wr_addr    = slot17[AW-1:0];
    wr_data    = shift14[TAG_W-1:0];

    case (s1_op_r)
      OP_ALLOC: begin
        if (plain_end > {1'b0, lim}) begin
          status_nxt = ST_NO_SPACE;
        end else begin
          result_nxt = top_r;
          top_nxt    = plain_end[12:0];
        end
      end
      OP_ALIGNED: begin
        if (!algn_ok || (algn_end > {2'b0, lim})) begin
          status_nxt = ST_NO_SPACE;
        end else begin
          result_nxt = aligned14[12:0];
          top_nxt    = algn_end[12:0];
          wr_en      = s1_fire && (slot17 < RB17);
        end
      end
      OP_LOOKUP: begin
        if (s1_lk_null_r) begin
          status_nxt = ST_NULL;
        end else begin
          result_nxt = s1_offs_r - {4'b0, shift9};
        end
      end
      OP_FREE: begin
        if (s1_offs_r > top_r) begin
          status_nxt = ST_BAD_MARKER;
        end else begin
          top_nxt = s1_offs_r;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_size_r <= REGION_SIZE_RST;
      top_r         <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        region_size_r <= cfg_wr_data;
      end
      if (s1_fire) begin
        top_r <= top_nxt;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r      <= in_op;
      s1_size_r    <= in_size;
      s1_align_r   <= in_align;
      s1_offs_r    <= in_offs;
      s1_lk_null_r <= in_lk_null;
    end
    if (s1_fire) begin
      out_status_r <= status_nxt;
      out_result_r <= result_nxt;
      out_top_r    <= top_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_top_r, out_result_r};
  assign out_tuser  = out_status_r;

endmodule

[sv/asa_checker.sv]
// Port-level checks for the aligned stack allocator and their binding.
module asa_checker
  import asa_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Failed requests carry a zero result offset.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tdata[12:0] == 13'd0)
    else $error("nonzero result offset on a failed request");

  // Outside reset, input back-pressure only arises from a pending result.
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a stalled result");

endmodule

bind aligned_stack_allocator_top asa_checker u_asa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[sim/tb.sv]
// Self-checking testbench for the aligned stack allocator top level.
`timescale 1ns / 1ps

module tb;
  import asa_pkg::*;

  // One request beat, unpacked into its fields.
  typedef struct {
    logic [1:0]         op;
    logic [OFFS_W-1:0]  size;
    logic [ALIGN_W-1:0] align;
    logic [OFFS_W-1:0]  offs;
    logic               is_null;
  } stack_req_t;

  // One result beat, unpacked into its fields.
  typedef struct {
    logic [1:0]        status;
    logic [OFFS_W-1:0] result_offset;
    logic [OFFS_W-1:0] top_after;
  } stack_resp_t;

  // The usable region can never exceed the tag memory of the block.
  localparam int unsigned REGION_CAP = REGION_BYTES_DEF;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [OFFS_W-1:0]     cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [12:0] size_bytes, [21:13] alignment, [34:22] offset_in, [39:35] zero
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // [1:0] operation, [2] offset_is_null
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [12:0] result_offset, [25:13] top_after, [31:26] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  // [1:0] status
  logic [OUT_USER_W-1:0] out_tuser;

  // Shadow copy of the allocator: top pointer, region size and the shift tag bytes.
  // Each tag carries a flag that tells whether it was ever written, so that a lookup
  // is only aimed at an entry that holds a defined value.
  int unsigned stack_top = 0;
  int unsigned region_sz = REGION_SIZE_RST;
  logic [TAG_W-1:0] shift_tag [REGION_CAP];
  bit               tag_valid [REGION_CAP];
  int unsigned      tagged_offsets [$];

  // Results predicted for accepted requests, oldest first.
  stack_resp_t replies_due [$];
  int          mismatch_count = 0;

  // Idle and stall rates, in percent, for the current phase.
  int send_idle_pct  = 13;
  int recv_stall_pct = 70;

  aligned_stack_allocator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The block's behavior, applied to the shadow state for one accepted request.
  // Reservation checks are done in 32-bit arithmetic so that no sum can wrap.
  function automatic stack_resp_t serve_request(stack_req_t r);
    stack_resp_t res;
    int unsigned limit;
    int unsigned a;
    int unsigned start;
    int unsigned aligned;
    int unsigned shift;
    res.status        = ST_OK;
    res.result_offset = '0;
    limit = (region_sz > REGION_CAP) ? REGION_CAP : region_sz;
    a     = r.align;
    case (r.op)
      OP_ALLOC: begin
        if (stack_top + r.size > limit) begin
          res.status = ST_NO_SPACE;
        end else begin
          res.result_offset = OFFS_W'(stack_top);
          stack_top         = stack_top + r.size;
        end
      end
      OP_ALIGNED: begin
        // A zero, a non-power-of-two or an oversized alignment is refused outright.
        if (a == 0 || (a & (a - 1)) != 0 || a > MAX_ALIGN_DEF) begin
          res.status = ST_NO_SPACE;
        end else if (stack_top + r.size + a > limit) begin
          res.status = ST_NO_SPACE;
        end else begin
          start     = stack_top;
          stack_top = start + r.size + a;
          aligned   = (start + a - 1) & ~(a - 1);
          // An already aligned top still moves by one full step, so there is
          // always room for the shift byte just below the result.
          if (aligned == start) begin
            aligned = aligned + a;
          end
          if (aligned - 1 < REGION_CAP) begin
            shift_tag[aligned - 1] = TAG_W'((aligned - start) & 8'hff);
            if (!tag_valid[aligned - 1]) begin
              tag_valid[aligned - 1] = 1'b1;
              tagged_offsets.push_back(aligned);
            end
          end
          res.result_offset = OFFS_W'(aligned);
        end
      end
      OP_LOOKUP: begin
        // A null pointer, and an offset with no tag byte below it, answer as null.
        if (r.is_null || r.offs == 0 || r.offs > REGION_CAP) begin
          res.status = ST_NULL;
        end else begin
          shift = shift_tag[r.offs - 1];
          if (shift == 0) begin
            shift = 256;
          end
          res.result_offset = OFFS_W'((r.offs - shift) & 13'h1fff);
        end
      end
      default: begin
        if (r.offs > stack_top) begin
          res.status = ST_BAD_MARKER;
        end else begin
          stack_top = r.offs;
        end
      end
    endcase
    res.top_after = OFFS_W'(stack_top);
    return res;
  endfunction

  function automatic stack_req_t make_req(logic [1:0] op, int unsigned size,
                                          int unsigned align, int unsigned offs,
                                          bit is_null);
    stack_req_t r;
    r.op      = op;
    r.size    = OFFS_W'(size);
    r.align   = ALIGN_W'(align);
    r.offs    = OFFS_W'(offs);
    r.is_null = is_null;
    return r;
  endfunction

  // Sends one request beat, idling first at the phase's rate. The valid is only
  // lowered while idling, so back-to-back beats keep it high. The prediction is made
  // at the accepting edge, so it always sees the state left by every earlier request.
  task automatic issue_request(stack_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, r.offs, r.align, r.size};
    in_tuser  <= {r.is_null, r.op};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    replies_due.push_back(serve_request(r));
  endtask

  // Holds back the sender until every predicted result has come, then lets the
  // pipeline run empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Region size writes happen only with the pipeline empty.
  task automatic set_region_size(int unsigned v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= OFFS_W'(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    region_sz    = v;
  endtask

  // Mostly small requests, now and then one across the whole region.
  function automatic int unsigned pick_size();
    return ($urandom_range(99) < 85) ? $urandom_range(0, 48) : $urandom_range(0, 4096);
  endfunction

  // Mostly legal alignments; the rest is any 9-bit value, illegal ones included.
  function automatic int unsigned pick_align();
    return ($urandom_range(99) < 90) ? (1 << $urandom_range(0, 8)) : $urandom_range(0, 511);
  endfunction

  // Random request shaped by the current shadow state: frees mostly hit a marker at
  // or below the top, and lookups mostly target offsets that carry a written tag.
  function automatic stack_req_t random_request();
    stack_req_t r;
    int unsigned roll;
    r.op      = OP_ALLOC;
    r.size    = OFFS_W'($urandom_range(0, 8191));
    r.align   = ALIGN_W'($urandom_range(0, 511));
    r.offs    = OFFS_W'($urandom_range(0, 8191));
    r.is_null = 1'($urandom_range(0, 1));
    roll      = $urandom_range(99);
    if (roll < 30) begin
      r.op   = OP_ALLOC;
      r.size = OFFS_W'(pick_size());
    end else if (roll < 60) begin
      r.op    = OP_ALIGNED;
      r.size  = OFFS_W'(pick_size());
      r.align = ALIGN_W'(pick_align());
    end else if (roll < 80) begin
      r.op = OP_LOOKUP;
      roll = $urandom_range(99);
      if (roll < 70 && tagged_offsets.size() != 0) begin
        r.offs    = OFFS_W'(tagged_offsets[$urandom_range(0, tagged_offsets.size() - 1)]);
        r.is_null = 1'b0;
      end else if (roll < 85) begin
        r.is_null = 1'b1;
      end else begin
        // Offset zero or past the region never reads a tag byte.
        r.offs    = OFFS_W'(($urandom_range(0, 1) != 0) ? 0 :
                            $urandom_range(REGION_CAP + 1, 8191));
        r.is_null = 1'b0;
      end
    end else begin
      r.op = OP_FREE;
      if ($urandom_range(99) < 85) begin
        r.offs = OFFS_W'($urandom_range(0, stack_top));
      end
    end
    return r;
  endfunction

  // Field extremes, every operation and the corner cases at the default region size.
  task automatic test_directed();
    issue_request(make_req(OP_ALLOC, 0, 1, 0, 0));
    issue_request(make_req(OP_ALLOC, 4096, 1, 0, 0));      // fills the region exactly
    issue_request(make_req(OP_ALLOC, 1, 1, 0, 0));         // does not fit
    issue_request(make_req(OP_FREE, 0, 0, 4096, 0));       // marker equal to top
    issue_request(make_req(OP_FREE, 0, 0, 8191, 0));       // marker above top
    issue_request(make_req(OP_FREE, 0, 0, 0, 0));
    issue_request(make_req(OP_ALIGNED, 10, 1, 0, 0));      // aligned top moves one step
    issue_request(make_req(OP_ALIGNED, 3, 256, 0, 0));
    issue_request(make_req(OP_ALIGNED, 0, 16, 0, 0));
    issue_request(make_req(OP_ALIGNED, 5, 0, 0, 0));       // zero alignment
    issue_request(make_req(OP_ALIGNED, 5, 3, 0, 0));       // not a power of two
    issue_request(make_req(OP_ALIGNED, 5, 511, 0, 0));     // above the maximum
    issue_request(make_req(OP_ALIGNED, 4096, 256, 0, 0));  // does not fit
    issue_request(make_req(OP_FREE, 0, 0, 256, 0));
    issue_request(make_req(OP_ALIGNED, 4, 256, 0, 0));     // shift of 256 stored as zero
    issue_request(make_req(OP_LOOKUP, 0, 0, 512, 0));
    issue_request(make_req(OP_LOOKUP, 0, 0, 1, 0));
    issue_request(make_req(OP_LOOKUP, 0, 0, 256, 0));
    issue_request(make_req(OP_LOOKUP, 0, 0, 272, 0));
    issue_request(make_req(OP_LOOKUP, 0, 0, 512, 1));      // null pointer
    issue_request(make_req(OP_LOOKUP, 0, 0, 0, 0));        // nothing below offset zero
    issue_request(make_req(OP_LOOKUP, 0, 0, 4097, 0));     // past the region
    issue_request(make_req(OP_LOOKUP, 0, 0, 8191, 0));
    issue_request(make_req(OP_FREE, 0, 0, 600, 0));        // marker above top
  endtask

  // Shrinks the region below the current top, then down to a single byte.
  task automatic test_region_limits();
    set_region_size(100);
    issue_request(make_req(OP_ALLOC, 0, 1, 0, 0));     // top already past the limit
    issue_request(make_req(OP_ALIGNED, 0, 1, 0, 0));
    issue_request(make_req(OP_FREE, 0, 0, 50, 0));     // freeing still works
    issue_request(make_req(OP_ALLOC, 50, 1, 0, 0));    // ends exactly at the limit
    issue_request(make_req(OP_ALLOC, 0, 1, 0, 0));
    issue_request(make_req(OP_ALLOC, 1, 1, 0, 0));
    set_region_size(1);
    issue_request(make_req(OP_FREE, 0, 0, 0, 0));
    issue_request(make_req(OP_ALIGNED, 0, 1, 0, 0));   // takes the only byte
    issue_request(make_req(OP_ALLOC, 0, 1, 0, 0));
    issue_request(make_req(OP_ALLOC, 1, 1, 0, 0));
  endtask

  task automatic test_random(int unsigned count);
    repeat (count) begin
      issue_request(random_request());
    end
  endtask

  task automatic flag_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: takes every result beat, compares it with the oldest prediction,
  // and draws the ready for the next edge at the phase's stall rate.
  always @(posedge clk) begin : check_replies
    stack_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result beat with none expected, status %0d, result %0d, top %0d",
                 $time, out_tuser[1:0], out_tdata[12:0], out_tdata[25:13]);
        mismatch_count++;
      end else begin
        want = replies_due.pop_front();
        flag_field("status", want.status, out_tuser[1:0]);
        flag_field("result_offset", want.result_offset, out_tdata[12:0]);
        flag_field("top_after", want.top_after, out_tdata[25:13]);
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Sender mostly busy, receiver stalling often.
    send_idle_pct  = 13;
    recv_stall_pct = 70;
    test_directed();
    test_region_limits();
    set_region_size(4096);
    test_random(240);

    // Sender mostly idle, receiver mostly ready, in a random region size.
    settle();
    send_idle_pct  = 70;
    recv_stall_pct = 13;
    set_region_size($urandom_range(200, 4095));
    test_random(230);

    // Full rate on both sides with the largest region.
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_region_size(4096);
    test_random(230);

    settle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
